// ===== rtl/scanner_line_deframer_defines.svh =====
// Assertion macros shared by the scanner line deframer checkers.
// No dependencies; included by sld_checker.sv.
`ifndef SCANNER_LINE_DEFRAMER_DEFINES_SVH
`define SCANNER_LINE_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define SLD_ASSERT_IMP(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("sld_checker: property failed");

// next-cycle implication
`define SLD_ASSERT_NXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("sld_checker: property failed");

`endif

// ===== rtl/sld_pkg.sv =====
// Package for the scanner line deframer: payload types, codes, ID tables,
// controller/datapath interface structs. No dependencies.
package sld_pkg;

  localparam int LINE_DEPTH_DEF = 64;
  localparam int CHAR_W         = 7;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_1D    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_2D    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd2;

  localparam logic [15:0] TIMEOUT_RST = 16'd400;

  localparam logic       OP_BYTE = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  localparam logic [7:0] BYTE_STX  = 8'h02;
  localparam logic [7:0] BYTE_NUL  = 8'h00;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] PRINT_LO  = 8'd32;
  localparam logic [7:0] PRINT_HI  = 8'd126;
  localparam logic [2:0] ACK_SKIP_LEN = 3'd5;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_SAW_STX = 2'd1;
  localparam logic [1:0] PH_SKIP    = 2'd2;

  localparam logic [1:0] SYM_RAW = 2'd0;
  localparam logic [1:0] SYM_1D  = 2'd1;
  localparam logic [1:0] SYM_2D  = 2'd2;

  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_BLOCK = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } sld_in_t;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] code_char;
    logic [1:0]        symbology;
    logic              last;
    logic              truncated;
  } sld_out_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic emit_char;
    logic emit_block;
  } sld_cmd_t;

  typedef struct packed {
    logic eol;
    logic blocked;
    logic at_last;
    logic out_free;
  } sld_status_t;

  // 2D IDs: Q u r
  function automatic logic id_is_2d(input logic [CHAR_W-1:0] c);
    return c == 7'h51 || c == 7'h75 || c == 7'h72;
  endfunction

  // 1D IDs: d c j b i a e D v H m R
  function automatic logic id_is_1d(input logic [CHAR_W-1:0] c);
    return c == 7'h64 || c == 7'h63 || c == 7'h6A || c == 7'h62 ||
           c == 7'h69 || c == 7'h61 || c == 7'h65 || c == 7'h44 ||
           c == 7'h76 || c == 7'h48 || c == 7'h6D || c == 7'h52;
  endfunction

endpackage

// ===== rtl/sld_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sld_datapath.sv =====
// Datapath: config registers, ack-frame filter, line store, idle timer and
// output register. Depends on sld_pkg and sld_ram.
module sld_datapath import sld_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sld_in_t               in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output sld_out_t              out_data,
  input  sld_cmd_t              cmd,
  output sld_status_t           st
);

  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int LW = $clog2(LINE_DEPTH + 1);

  logic            en1d_r, en1d_nxt;
  logic            en2d_r, en2d_nxt;
  logic [15:0]     tmo_r, tmo_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [2:0]      skip_r, skip_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [15:0]     idle_r, idle_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CHAR_W-1:0] first_r, first_nxt;
  logic [1:0]      sym_r, sym_nxt;
  logic [AW-1:0]   rd_idx_r, rd_idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  sld_out_t        out_r, out_nxt;

  logic              ram_we;
  logic [CHAR_W-1:0] ram_rdata;
  logic [15:0]       idle_inc;
  logic [2:0]        skip_dec;
  logic [1:0]        line_sym;
  logic              normal;
  logic              eol;
  logic              out_free;
  logic              at_last;
  logic [7:0]        b;

  assign b = in_data.rx_byte;

  sld_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[AW-1:0]),
    .wdata (b[CHAR_W-1:0]),
    .re    (cmd.rd_en),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  assign idle_inc = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
  assign skip_dec = (skip_r == 3'd0) ? 3'd0 : skip_r - 3'd1;
  assign out_free = !out_valid_r || !out_stall;
  assign at_last  = (LW'(rd_idx_r) + LW'(1)) == len_r;

  always_comb begin
    line_sym = SYM_RAW;
    if (len_r >= LW'(2)) begin
      if (id_is_2d(first_r)) begin
        line_sym = SYM_2D;
      end else if (id_is_1d(first_r)) begin
        line_sym = SYM_1D;
      end
    end
  end

  always_comb begin
    en1d_nxt      = en1d_r;
    en2d_nxt      = en2d_r;
    tmo_nxt       = tmo_r;
    phase_nxt     = phase_r;
    skip_nxt      = skip_r;
    len_nxt       = len_r;
    idle_nxt      = idle_r;
    ovf_nxt       = ovf_r;
    first_nxt     = first_r;
    sym_nxt       = sym_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    normal        = 1'b0;
    eol           = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE_1D:    en1d_nxt = cfg_data[0];
        CFG_ENABLE_2D:    en2d_nxt = cfg_data[0];
        CFG_IDLE_TIMEOUT: tmo_nxt  = cfg_data;
        default: ;
      endcase
    end

    if (cmd.accept) begin
      if (in_data.operation == OP_TICK) begin
        if (len_r != '0) begin
          if (idle_inc >= tmo_r) begin
            len_nxt  = '0;
            idle_nxt = '0;
            ovf_nxt  = 1'b0;
          end else begin
            idle_nxt = idle_inc;
          end
        end
      end else begin
        if (phase_r == PH_SKIP) begin
          skip_nxt = skip_dec;
          if (skip_dec == 3'd0) begin
            phase_nxt = PH_IDLE;
          end
        end else if (phase_r == PH_SAW_STX && b == BYTE_NUL) begin
          phase_nxt = PH_SKIP;
          skip_nxt  = ACK_SKIP_LEN;
        end else begin
          phase_nxt = PH_IDLE;
          normal    = 1'b1;
        end

        if (normal) begin
          if (b == BYTE_STX) begin
            phase_nxt = PH_SAW_STX;
          end else if (b == BYTE_CR || b == BYTE_LF) begin
            if (len_r != '0) begin
              eol        = 1'b1;
              sym_nxt    = line_sym;
              rd_idx_nxt = (line_sym != SYM_RAW) ? AW'(1) : '0;
            end
          end else if (b >= PRINT_LO && b <= PRINT_HI) begin
            if (len_r < LW'(LINE_DEPTH)) begin
              ram_we  = 1'b1;
              len_nxt = len_r + LW'(1);
              if (len_r == '0) begin
                first_nxt = b[CHAR_W-1:0];
              end
            end else begin
              ovf_nxt = 1'b1;
            end
            idle_nxt = '0;
          end
        end
      end
    end

    if (cmd.emit_char) begin
      out_valid_nxt     = 1'b1;
      out_nxt.kind      = KIND_CHAR;
      out_nxt.code_char = ram_rdata;
      out_nxt.symbology = sym_r;
      out_nxt.last      = at_last;
      out_nxt.truncated = ovf_r;
      rd_idx_nxt        = rd_idx_r + AW'(1);
      if (at_last) begin
        len_nxt  = '0;
        idle_nxt = '0;
        ovf_nxt  = 1'b0;
      end
    end

    if (cmd.emit_block) begin
      out_valid_nxt     = 1'b1;
      out_nxt.kind      = KIND_BLOCK;
      out_nxt.code_char = '0;
      out_nxt.symbology = sym_r;
      out_nxt.last      = 1'b1;
      out_nxt.truncated = ovf_r;
      len_nxt           = '0;
      idle_nxt          = '0;
      ovf_nxt           = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en1d_r      <= 1'b1;
      en2d_r      <= 1'b1;
      tmo_r       <= TIMEOUT_RST;
      phase_r     <= PH_IDLE;
      skip_r      <= '0;
      len_r       <= '0;
      idle_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      en1d_r      <= en1d_nxt;
      en2d_r      <= en2d_nxt;
      tmo_r       <= tmo_nxt;
      phase_r     <= phase_nxt;
      skip_r      <= skip_nxt;
      len_r       <= len_nxt;
      idle_r      <= idle_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r  <= first_nxt;
    sym_r    <= sym_nxt;
    rd_idx_r <= rd_idx_nxt;
    out_r    <= out_nxt;
  end

  assign st.eol      = eol;
  assign st.blocked  = (line_sym == SYM_1D && !en1d_r) || (line_sym == SYM_2D && !en2d_r);
  assign st.at_last  = at_last;
  assign st.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/sld_ctrl.sv =====
// Controller FSM: input handshake and line emission sequencing.
// Depends on sld_pkg.
module sld_ctrl import sld_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  sld_status_t st,
  output sld_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_LOAD  = 2'd2;
  localparam logic [1:0] ST_BLOCK = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && st.eol) begin
          state_nxt = st.blocked ? ST_BLOCK : ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (st.out_free) begin
          cmd.emit_char = 1'b1;
          state_nxt     = st.at_last ? ST_IDLE : ST_READ;
        end
      end
      ST_BLOCK: begin
        if (st.out_free) begin
          cmd.emit_block = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// ===== rtl/scanner_line_deframer.sv =====
// Scanner line deframer top level: controller plus datapath.
// Depends on sld_pkg, sld_ctrl, sld_datapath (and sld_ram below it).
//
//   channel | signals                       | direction
//   in      | in_valid/in_stall, in_data    | bytes and ticks in
//   out     | out_valid/out_stall, out_data | code characters or blocked mark
//   cfg     | cfg_valid/cfg_ready, index    | enable_1d, enable_2d, timeout
//
// A byte or tick is taken when no line is being emitted.
// A finished line is emitted as a store read then an output load for each
// character, or as one blocked mark; input stalls meanwhile.
// out_stall holds the output register and pauses the line walk.
// Reset is synchronous; the line store is not cleared and needs no sweep.
module scanner_line_deframer import sld_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sld_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sld_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sld_cmd_t    cmd;
  sld_status_t st;

  assign cfg_ready = 1'b1;

  sld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  sld_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ===== rtl/sld_checker.sv =====
// Port-level checker for scanner_line_deframer, bound to the top level.
// Depends on sld_pkg and scanner_line_deframer_defines.svh.
`include "scanner_line_deframer_defines.svh"

module sld_checker import sld_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input sld_in_t               in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input sld_out_t              out_data,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // stalled result holds
  `SLD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  // blocked result is a single last item with no character
  `SLD_ASSERT_IMP(a_block_form, clk, rst_n, out_valid && out_data.kind == KIND_BLOCK, out_data.last && out_data.code_char == '0 && out_data.symbology != SYM_RAW)
  // mid-line: more characters pending, input must be held off
  `SLD_ASSERT_IMP(a_midline_stall, clk, rst_n, out_valid && !out_data.last, in_stall)
  // symbology code is always defined
  `SLD_ASSERT_IMP(a_sym_code, clk, rst_n, out_valid, out_data.symbology == SYM_RAW || out_data.symbology == SYM_1D || out_data.symbology == SYM_2D)

endmodule

bind scanner_line_deframer sld_checker u_sld_checker (.*);
